FILE: hw/rtl/acfp_pkg.sv
`timescale 1ns / 1ps

package acfp_pkg;

  // item kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // parser phases
  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_NAME     = 2'd1;
  localparam logic [1:0] PH_PAYLOAD  = 2'd2;
  localparam logic [1:0] PH_COMPLETE = 2'd3;

  // reported events
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_HEADER   = 3'd1;
  localparam logic [2:0] EV_MATCHED  = 3'd2;
  localparam logic [2:0] EV_COMPLETE = 3'd3;
  localparam logic [2:0] EV_ERROR    = 3'd4;
  localparam logic [2:0] EV_OVERFLOW = 3'd5;

  localparam logic [7:0] HDR_A  = 8'h41;
  localparam logic [7:0] HDR_T  = 8'h54;
  localparam logic [7:0] HDR_PL = 8'h2B;
  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_LF = 8'h0A;

  localparam int NAME_COUNT = 6;
  localparam logic [3:0] NAME_MAX = 4'd10;
  localparam logic [NAME_COUNT-1:0] ALL_ALIVE = '1;

  // names left aligned, padded with spaces that are never compared
  localparam logic [9:0][7:0] NAME_TEXT [NAME_COUNT] = '{
    "SET_LED:  ", "GET_TIME  ", "SET_TIME: ",
    "SHOW_TIME ", "SHOW_DATE:", {"SHOW_", "TEXT:"}
  };
  localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
    4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10
  };

  localparam int QUEUE_DEPTH = 2;

  function automatic logic [7:0] name_char(input logic [2:0] id, input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos < NAME_MAX) begin
      ch = NAME_TEXT[id][4'd9 - pos];
    end
    return ch;
  endfunction

  // one result as it travels from the parser to the output stage
  typedef struct packed {
    logic [1:0] phase;
    logic [2:0] event_res;
    logic [2:0] command_id;
    logic [7:0] payload_length;
    logic       read_ok;
    logic [6:0] read_index;
  } rec_t;

endpackage

FILE: hw/rtl/acfp_ram.sv
`timescale 1ns / 1ps

module acfp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/acfp_front.sv
`timescale 1ns / 1ps

module acfp_front #(
  parameter int PAYLOAD_DEPTH = 128,
  parameter int ADDR_W = $clog2(PAYLOAD_DEPTH),
  parameter int FILL_W = $clog2(PAYLOAD_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [1:0]          kind,
  input  logic [7:0]          in_byte,
  input  logic [6:0]          read_index,
  input  logic                q_full,
  output logic                q_push,
  output acfp_pkg::rec_t      q_rec,
  output logic                ram_we,
  output logic [ADDR_W-1:0]   ram_waddr,
  output logic [7:0]          ram_wdata
);

  localparam int CMP_W = (FILL_W > 7) ? FILL_W : 7;

  logic [1:0]                      phase, phase_next;
  logic [7:0]                      win [3];
  logic [7:0]                      win_next [3];
  logic [3:0]                      name_pos, name_pos_next;
  logic [acfp_pkg::NAME_COUNT-1:0] alive, alive_next;
  logic [2:0]                      cmd, cmd_next;
  logic [FILL_W-1:0]               fill, fill_next;

  logic                            accept;
  logic [2:0]                      ev;
  logic                            rd_ok;
  logic [acfp_pkg::NAME_COUNT-1:0] alive_m;
  logic [acfp_pkg::NAME_COUNT-1:0] hit;
  logic [2:0]                      hit_id;
  logic [3:0]                      pos_inc;
  logic [CMP_W-1:0]                idx_ext, fill_ext;
  logic [FILL_W+7:0]               len_ext;

  assign accept    = push && !q_full;
  assign ram_wdata = in_byte;
  assign ram_waddr = fill[ADDR_W-1:0];
  assign pos_inc   = name_pos + 4'd1;
  assign idx_ext   = CMP_W'(read_index);
  assign fill_ext  = CMP_W'(fill);

  // per-position compare against every name that is still a candidate
  always_comb begin
    alive_m = alive;
    hit     = '0;
    hit_id  = 3'd0;
    for (int i = 0; i < acfp_pkg::NAME_COUNT; i++) begin
      if (name_pos < acfp_pkg::NAME_LEN[i] &&
          acfp_pkg::name_char(3'(i), name_pos) != in_byte) begin
        alive_m[i] = 1'b0;
      end
      hit[i] = alive_m[i] && (acfp_pkg::NAME_LEN[i] == pos_inc);
    end
    for (int i = acfp_pkg::NAME_COUNT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_id = 3'(i);
      end
    end
  end

  always_comb begin
    phase_next    = phase;
    win_next      = win;
    name_pos_next = name_pos;
    alive_next    = alive;
    cmd_next      = cmd;
    fill_next     = fill;
    ev            = acfp_pkg::EV_NONE;
    rd_ok         = 1'b0;
    ram_we        = 1'b0;
    unique case (kind)
      acfp_pkg::KIND_BYTE: begin
        unique case (phase)
          acfp_pkg::PH_HEADER: begin
            win_next[0] = win[1];
            win_next[1] = win[2];
            win_next[2] = in_byte;
            if (win[1] == acfp_pkg::HDR_A && win[2] == acfp_pkg::HDR_T &&
                in_byte == acfp_pkg::HDR_PL) begin
              win_next      = '{default: 8'h00};
              name_pos_next = 4'd0;
              alive_next    = acfp_pkg::ALL_ALIVE;
              cmd_next      = 3'd0;
              phase_next    = acfp_pkg::PH_NAME;
              ev            = acfp_pkg::EV_HEADER;
            end
          end
          acfp_pkg::PH_NAME: begin
            name_pos_next = pos_inc;
            alive_next    = alive_m;
            if (|hit) begin
              cmd_next   = hit_id;
              fill_next  = '0;
              phase_next = acfp_pkg::PH_PAYLOAD;
              ev         = acfp_pkg::EV_MATCHED;
            end else if (pos_inc >= acfp_pkg::NAME_MAX) begin
              // no name left: go back to searching with the rest of the stream
              win_next      = '{default: 8'h00};
              name_pos_next = 4'd0;
              alive_next    = acfp_pkg::ALL_ALIVE;
              phase_next    = acfp_pkg::PH_HEADER;
              ev            = acfp_pkg::EV_ERROR;
            end
          end
          acfp_pkg::PH_PAYLOAD: begin
            if (in_byte == acfp_pkg::CHR_CR || in_byte == acfp_pkg::CHR_LF) begin
              phase_next = acfp_pkg::PH_COMPLETE;
              ev         = acfp_pkg::EV_COMPLETE;
            end else if (fill < FILL_W'(PAYLOAD_DEPTH)) begin
              ram_we    = accept;
              fill_next = fill + FILL_W'(1);
            end else begin
              ev = acfp_pkg::EV_OVERFLOW;
            end
          end
          acfp_pkg::PH_COMPLETE: begin
          end
          default: begin
          end
        endcase
      end
      acfp_pkg::KIND_READ: begin
        rd_ok = (phase == acfp_pkg::PH_COMPLETE) && (idx_ext < fill_ext);
      end
      acfp_pkg::KIND_CLEAR: begin
        phase_next    = acfp_pkg::PH_HEADER;
        win_next      = '{default: 8'h00};
        name_pos_next = 4'd0;
        alive_next    = acfp_pkg::ALL_ALIVE;
        cmd_next      = 3'd0;
        fill_next     = '0;
      end
      default: begin
      end
    endcase
  end

  assign len_ext = {8'h00, fill_next};

  always_comb begin
    q_push               = accept;
    q_rec.phase          = phase_next;
    q_rec.event_res      = ev;
    q_rec.command_id     = cmd_next;
    q_rec.payload_length = len_ext[7:0];
    q_rec.read_ok        = rd_ok;
    q_rec.read_index     = read_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= acfp_pkg::PH_HEADER;
      win      <= '{default: 8'h00};
      name_pos <= 4'd0;
      alive    <= acfp_pkg::ALL_ALIVE;
      cmd      <= 3'd0;
      fill     <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      win      <= win_next;
      name_pos <= name_pos_next;
      alive    <= alive_next;
      cmd      <= cmd_next;
      fill     <= fill_next;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(PAYLOAD_DEPTH))
    else $error("payload fill beyond depth");

  a_write_in_payload: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (phase == acfp_pkg::PH_PAYLOAD && accept && fill < FILL_W'(PAYLOAD_DEPTH)))
    else $error("payload write outside payload phase");

  a_clear_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == acfp_pkg::KIND_CLEAR) |=>
      (phase == acfp_pkg::PH_HEADER && fill == '0 && alive == acfp_pkg::ALL_ALIVE))
    else $error("clear did not restart the parser");
`endif

endmodule

FILE: hw/rtl/acfp_fifo.sv
`timescale 1ns / 1ps

module acfp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  acfp_pkg::rec_t din,
  output logic           full,
  input  logic           pop,
  output acfp_pkg::rec_t dout,
  output logic           empty
);

  localparam int PTR_W = $clog2(acfp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(acfp_pkg::QUEUE_DEPTH + 1);

  acfp_pkg::rec_t   slots [acfp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(acfp_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(acfp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(acfp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/acfp_back.sv
`timescale 1ns / 1ps

module acfp_back #(
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  acfp_pkg::rec_t    q_dout,
  output logic              q_pop,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        phase,
  output logic [2:0]        event_res,
  output logic [2:0]        command_id,
  output logic [7:0]        payload_length,
  output logic [7:0]        read_byte,
  output logic              read_ok
);

  logic              s1_valid;
  acfp_pkg::rec_t    s1_rec;
  logic              out_valid;
  logic              s1_move;
  logic [ADDR_W+6:0] addr_ext;

  assign s1_move   = s1_valid && (!out_valid || pop);
  assign q_pop     = !q_empty && (!s1_valid || s1_move);
  assign addr_ext  = {{ADDR_W{1'b0}}, q_dout.read_index};
  // read data only updates when a new transaction enters the read stage
  assign ram_re    = q_pop;
  assign ram_raddr = addr_ext[ADDR_W-1:0];
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_rec <= q_dout;
    end
    if (s1_move) begin
      phase          <= s1_rec.phase;
      event_res      <= s1_rec.event_res;
      command_id     <= s1_rec.command_id;
      payload_length <= s1_rec.payload_length;
      read_ok        <= s1_rec.read_ok;
      read_byte      <= s1_rec.read_ok ? ram_rdata : 8'h00;
    end
  end

endmodule

FILE: hw/rtl/at_command_frame_parser.sv
`timescale 1ns / 1ps

// AT command frame parser. Every transaction (received byte, payload read,
// clear or unused kind) produces exactly one result, in order. One
// transaction is accepted per cycle while full is low; when pop keeps up the
// result moves from the queue through the read stage to the output ports. The
// parser front updates its state in the accept cycle and hands the result to a
// two-entry queue; the back stage reads the payload memory (one registered read
// port) and holds the result until popped. full rises only when that queue and
// both back stages are occupied because pop is low.
// Payload memory needs no clearing; reads are served only below the fill.
module at_command_frame_parser #(
  parameter int PAYLOAD_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] kind,
  input  logic [7:0] in_byte,
  input  logic [6:0] read_index,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] phase,
  output logic [2:0] event_res,
  output logic [2:0] command_id,
  output logic [7:0] payload_length,
  output logic [7:0] read_byte,
  output logic       read_ok
);

  localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);
  localparam int FILL_W = $clog2(PAYLOAD_DEPTH + 1);

  logic              q_push, q_full, q_pop, q_empty;
  acfp_pkg::rec_t    q_din, q_dout;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  assign full = q_full;

  acfp_front #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
    .ADDR_W        (ADDR_W),
    .FILL_W        (FILL_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .kind       (kind),
    .in_byte    (in_byte),
    .read_index (read_index),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (q_din),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  acfp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  acfp_ram #(
    .WIDTH  (8),
    .DEPTH  (PAYLOAD_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  acfp_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_dout         (q_dout),
    .q_pop          (q_pop),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .empty          (empty),
    .pop            (pop),
    .phase          (phase),
    .event_res      (event_res),
    .command_id     (command_id),
    .payload_length (payload_length),
    .read_byte      (read_byte),
    .read_ok        (read_ok)
  );

endmodule

FILE: tb/at_command_frame_parser_checker.sv
`timescale 1ns / 1ps

module at_command_frame_parser_checker #(
  parameter int STORE_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [1:0] kind,
  input  logic [7:0] in_byte,
  input  logic [6:0] read_index,
  input  logic       empty,
  input  logic       pop,
  input  logic [1:0] phase,
  input  logic [2:0] event_res,
  input  logic [2:0] command_id,
  input  logic [7:0] payload_length,
  input  logic [7:0] read_byte,
  input  logic       read_ok,
  output int         mismatch_count,
  output int         replies_pending
);

  typedef struct packed {
    logic [1:0] phase;
    logic [2:0] event_res;
    logic [2:0] command_id;
    logic [7:0] payload_length;
    logic [7:0] read_byte;
    logic       read_ok;
  } parser_reply_t;

  string command_names [acfp_pkg::NAME_COUNT] = '{
    "SET_LED:", "GET_TIME", "SET_TIME:", "SHOW_TIME", "SHOW_DATE:",
    string'({"SHOW_", "TEXT:"})
  };

  // shadow copy of the parser state
  logic [1:0]                      cur_phase;
  logic [7:0]                      window [3];
  int                              name_pos;
  logic [acfp_pkg::NAME_COUNT-1:0] alive;
  logic [2:0]                      cur_command;
  logic [7:0]                      payload [STORE_DEPTH];
  int                              fill;

  parser_reply_t expected_replies [$];
  parser_reply_t got, want;

  initial begin
    mismatch_count  = 0;
    replies_pending = 0;
  end

  function automatic void restart_parser();
    cur_phase   = acfp_pkg::PH_HEADER;
    window      = '{default: 8'h00};
    name_pos    = 0;
    alive       = acfp_pkg::ALL_ALIVE;
    cur_command = 3'd0;
    fill        = 0;
  endfunction

  function automatic logic [2:0] take_char(input logic [7:0] b);
    logic [2:0] ev;
    bit         found;
    ev    = acfp_pkg::EV_NONE;
    found = 0;
    case (cur_phase)
      acfp_pkg::PH_HEADER: begin
        window[0] = window[1];
        window[1] = window[2];
        window[2] = b;
        if (window[0] == acfp_pkg::HDR_A && window[1] == acfp_pkg::HDR_T &&
            window[2] == acfp_pkg::HDR_PL) begin
          window      = '{default: 8'h00};
          name_pos    = 0;
          alive       = acfp_pkg::ALL_ALIVE;
          cur_command = 3'd0;
          cur_phase   = acfp_pkg::PH_NAME;
          ev          = acfp_pkg::EV_HEADER;
        end
      end
      acfp_pkg::PH_NAME: begin
        for (int c = 0; c < acfp_pkg::NAME_COUNT; c++) begin
          if (name_pos < command_names[c].len() && 8'(command_names[c][name_pos]) != b)
            alive[c] = 1'b0;
        end
        name_pos++;
        // lowest table index wins when several names end here
        for (int c = 0; c < acfp_pkg::NAME_COUNT; c++) begin
          if (!found && alive[c] && command_names[c].len() == name_pos) begin
            found       = 1;
            cur_command = 3'(c);
            fill        = 0;
            cur_phase   = acfp_pkg::PH_PAYLOAD;
            ev          = acfp_pkg::EV_MATCHED;
          end
        end
        if (!found && name_pos >= int'(acfp_pkg::NAME_MAX)) begin
          window    = '{default: 8'h00};
          name_pos  = 0;
          alive     = acfp_pkg::ALL_ALIVE;
          cur_phase = acfp_pkg::PH_HEADER;
          ev        = acfp_pkg::EV_ERROR;
        end
      end
      acfp_pkg::PH_PAYLOAD: begin
        if (b == acfp_pkg::CHR_CR || b == acfp_pkg::CHR_LF) begin
          cur_phase = acfp_pkg::PH_COMPLETE;
          ev        = acfp_pkg::EV_COMPLETE;
        end else if (fill < STORE_DEPTH) begin
          payload[fill] = b;
          fill++;
        end else begin
          ev = acfp_pkg::EV_OVERFLOW;
        end
      end
      default: ;
    endcase
    return ev;
  endfunction

  function automatic parser_reply_t step_parser(input logic [1:0] k, input logic [7:0] b,
                                                input logic [6:0] idx);
    parser_reply_t r;
    r = '0;
    r.event_res = acfp_pkg::EV_NONE;
    case (k)
      acfp_pkg::KIND_BYTE: r.event_res = take_char(b);
      acfp_pkg::KIND_READ: begin
        if (cur_phase == acfp_pkg::PH_COMPLETE && int'(idx) < fill) begin
          r.read_byte = payload[idx];
          r.read_ok   = 1'b1;
        end
      end
      acfp_pkg::KIND_CLEAR: restart_parser();
      default: ;
    endcase
    r.phase          = cur_phase;
    r.command_id     = cur_command;
    r.payload_length = fill[7:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restart_parser();
      expected_replies.delete();
    end else begin
      // compare before predicting: a result never leaves in its own accept cycle
      if (pop && !empty) begin
        got = {phase, event_res, command_id, payload_length, read_byte, read_ok};
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result at %0t: phase %0d event %0d cmd %0d len %0d",
                     $realtime, got.phase, got.event_res, got.command_id, got.payload_length);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected phase %0d event %0d cmd %0d len %0d byte %02h ok %0d",
                       want.phase, want.event_res, want.command_id, want.payload_length,
                       want.read_byte, want.read_ok);
              $display("  actual   phase %0d event %0d cmd %0d len %0d byte %02h ok %0d",
                       got.phase, got.event_res, got.command_id, got.payload_length,
                       got.read_byte, got.read_ok);
            end
          end
        end
      end
      if (push && !full)
        expected_replies.push_back(step_parser(kind, in_byte, read_index));
    end
    replies_pending = expected_replies.size();
  end

endmodule

FILE: tb/at_command_frame_parser_tb.sv
`timescale 1ns / 1ps

module at_command_frame_parser_tb;

  localparam int PAYLOAD_DEPTH = 128;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 1800;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic       clk = 1'b0;
  logic       rst;
  logic       push;
  logic       full;
  logic [1:0] kind;
  logic [7:0] in_byte;
  logic [6:0] read_index;
  logic       empty;
  logic       pop;
  logic [1:0] phase;
  logic [2:0] event_res;
  logic [2:0] command_id;
  logic [7:0] payload_length;
  logic [7:0] read_byte;
  logic       read_ok;
  int         mismatch_count;
  int         replies_pending;

  int cycle_count = 0;
  int item_count  = 0;
  int frame_no;
  bit calm        = 0;
  bit tx_idle_en  = 1;
  bit rx_idle_en  = 1;
  bit long_stall  = 0;

  string name_pool [acfp_pkg::NAME_COUNT] = '{
    "SET_LED:", "GET_TIME", "SET_TIME:", "SHOW_TIME", "SHOW_DATE:",
    string'({"SHOW_", "TEXT:"})
  };

  at_command_frame_parser #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind), .in_byte(in_byte),
    .read_index(read_index), .empty(empty), .pop(pop), .phase(phase),
    .event_res(event_res), .command_id(command_id), .payload_length(payload_length),
    .read_byte(read_byte), .read_ok(read_ok)
  );

  at_command_frame_parser_checker #(.STORE_DEPTH(PAYLOAD_DEPTH)) u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random pop bursts, plus one long hold-off on request
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall) begin
        pop <= 1'b0;
        repeat (200) @(negedge clk);
        long_stall = 0;
      end else if (rx_idle_en && !calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) rx_idle_en = !rx_idle_en;
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [7:0] b, input logic [6:0] idx);
    if (tx_idle_en && !calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    push       <= 1'b1;
    kind       <= k;
    in_byte    <= b;
    read_index <= idx;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (k != KIND_SPARE) item_count++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(acfp_pkg::KIND_BYTE, b, 7'($urandom_range(0, 127)));
  endtask

  task automatic send_clear();
    send_item(acfp_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == acfp_pkg::CHR_CR || b == acfp_pkg::CHR_LF);
    return b;
  endfunction

  function automatic logic [7:0] header_noise();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0:       b = acfp_pkg::HDR_A;
      1:       b = acfp_pkg::HDR_T;
      2:       b = acfp_pkg::HDR_PL;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  task automatic drain_replies();
    push <= 1'b0;
    wait (replies_pending == 0);
    @(negedge clk);
  endtask

  // one command frame with random content; some frames are noise, broken or cut short
  task automatic send_frame(input bit long_payload);
    int pick, n, len, cut, top_idx;
    pick = $urandom_range(0, 9);
    tx_idle_en = ($urandom_range(0, 3) != 0);
    if (pick == 0) begin
      repeat ($urandom_range(3, 12)) begin
        case ($urandom_range(0, 3))
          0: send_item(acfp_pkg::KIND_READ, 8'($urandom_range(0, 255)),
                       7'($urandom_range(0, 127)));
          1: send_item(KIND_SPARE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
          default: send_byte(header_noise());
        endcase
      end
      return;
    end
    repeat ($urandom_range(0, 3)) send_byte(header_noise());
    send_byte(acfp_pkg::HDR_A);
    send_byte(acfp_pkg::HDR_T);
    send_byte(acfp_pkg::HDR_PL);
    n = $urandom_range(0, acfp_pkg::NAME_COUNT - 1);
    if (pick == 1) begin
      // name goes wrong part way, error expected on the tenth byte
      cut = $urandom_range(0, 7);
      for (int i = 0; i < 10; i++)
        send_byte(i < cut ? 8'(name_pool[n][i]) : 8'($urandom_range(0, 255)));
      return;
    end
    for (int i = 0; i < name_pool[n].len(); i++) send_byte(8'(name_pool[n][i]));
    if (long_payload) len = 40;
    else if ($urandom_range(0, 14) == 0) len = $urandom_range(120, 134);
    else len = $urandom_range(0, 12);
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == cut) begin
        send_clear();
        return;
      end
      send_byte(plain_byte());
    end
    if (cut == len) begin
      send_clear();
      return;
    end
    send_byte($urandom_range(0, 1) ? acfp_pkg::CHR_CR : acfp_pkg::CHR_LF);
    top_idx = (len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH - 1 : len - 1;
    repeat ($urandom_range(0, 5)) begin
      if (top_idx >= 0 && $urandom_range(0, 1))
        send_item(acfp_pkg::KIND_READ, 8'($urandom_range(0, 255)),
                  7'($urandom_range(0, top_idx)));
      else
        send_item(acfp_pkg::KIND_READ, 8'($urandom_range(0, 255)),
                  7'($urandom_range(0, 127)));
    end
    if ($urandom_range(0, 5) == 0) send_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0)
      send_item(KIND_SPARE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    send_clear();
  endtask

  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    kind       = acfp_pkg::KIND_BYTE;
    in_byte    = 8'h00;
    read_index = 7'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: spare kind, read out of phase, field extremes, one full command
    send_item(KIND_SPARE, 8'hFF, 7'h7F);
    send_item(acfp_pkg::KIND_READ, 8'h00, 7'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(acfp_pkg::HDR_A);
    send_byte(acfp_pkg::HDR_T);
    send_byte(acfp_pkg::HDR_PL);
    for (int i = 0; i < name_pool[1].len(); i++) send_byte(8'(name_pool[1][i]));
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(acfp_pkg::CHR_LF);
    send_item(acfp_pkg::KIND_READ, 8'hFF, 7'd0);
    send_item(acfp_pkg::KIND_READ, 8'h00, 7'd1);
    send_item(acfp_pkg::KIND_READ, 8'h00, 7'd2);
    send_item(acfp_pkg::KIND_READ, 8'h00, 7'h7F);
    send_byte("Z");
    send_item(acfp_pkg::KIND_CLEAR, 8'h00, 7'd0);

    item_count = 0;
    frame_no   = 0;
    while (item_count < RANDOM_ITEMS) begin
      if (frame_no == 12) begin
        // receiver holds off while this frame keeps coming, so the input stalls
        long_stall = 1;
        send_frame(1);
      end else begin
        if (frame_no == 30) drain_replies();
        send_frame(0);
      end
      calm = (item_count > RANDOM_ITEMS - 250);
      frame_no++;
    end

    drain_replies();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
